// ===== rtl/core/rk4st_pkg.sv =====
// Shared types and constants for the RK4 streamline tracer.
package rk4st_pkg;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_W      = 20;
  localparam int VEC_W      = 16;
  localparam int IDX_W      = 6;
  localparam int ADDR_MAX_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP        = 3'd4;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TRACE = 1'b1;

  typedef struct packed {
    logic                    trace;
    logic [ADDR_MAX_W-1:0]   addr;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
  } cmd_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
  } norm_req_t;

  typedef struct packed {
    logic               done;
    logic signed [17:0] ux;
    logic signed [17:0] uy;
  } norm_rsp_t;

endpackage

// ===== rtl/core/rk4st_front.sv =====
// Input side: accepts beats, decodes mode and resolves the clamped write cell.
module rk4st_front #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rk4st_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic [$clog2(GRID_W+1)-1:0]    eff_w,
  input  logic [$clog2(GRID_H+1)-1:0]    eff_h,
  input  logic                           busy,
  input  logic                           full,
  output logic                           push,
  output rk4st_pkg::cmd_t                cmd
);
  import rk4st_pkg::*;

  localparam int AW  = $clog2(GRID_W * GRID_H);
  localparam int CXW = $clog2(GRID_W);
  localparam int CYW = $clog2(GRID_H);

  logic signed [POS_W-1:0] px, py;
  logic signed [20:0]      px21, py21, wlim, hlim;
  logic [CXW-1:0]          cx;
  logic [CYW-1:0]          cy;
  logic [AW-1:0]           addr;

  assign in_tready = !full && !busy;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    px   = in_tdata[19:0];
    py   = in_tdata[39:20];
    px21 = px;
    py21 = py;
    wlim = $signed(21'(eff_w)) - 21'sd1;
    hlim = $signed(21'(eff_h)) - 21'sd1;
    if (px[POS_W-1]) begin
      cx = '0;
    end else if (px21 > wlim) begin
      cx = CXW'(wlim);
    end else begin
      cx = CXW'(px);
    end
    if (py[POS_W-1]) begin
      cy = '0;
    end else if (py21 > hlim) begin
      cy = CYW'(hlim);
    end else begin
      cy = CYW'(py);
    end
    addr      = AW'(AW'(cy) * AW'(eff_w)) + AW'(cx);
    cmd.trace = (in_tuser == MODE_TRACE);
    cmd.addr  = ADDR_MAX_W'(addr);
    cmd.pos_x = px;
    cmd.pos_y = py;
    cmd.vec_x = in_tdata[55:40];
    cmd.vec_y = in_tdata[71:56];
  end

endmodule

// ===== rtl/core/rk4st_queue.sv =====
// Two-entry command queue between the input side and the execution side.
module rk4st_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rk4st_pkg::cmd_t cmd_in,
  output logic            full,
  input  logic            pop,
  output rk4st_pkg::cmd_t cmd_out,
  output logic            empty
);
  import rk4st_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign cmd_out = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd_in;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/rk4st_norm.sv =====
// Vector normalizer: square sum, bit-serial square root, two restoring dividers.
module rk4st_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rk4st_pkg::norm_req_t req,
  output rk4st_pkg::norm_rsp_t rsp
);
  import rk4st_pkg::*;

  typedef enum logic [3:0] {
    N_IDLE = 4'b0001,
    N_SQ   = 4'b0010,
    N_ROOT = 4'b0100,
    N_DIV  = 4'b1000
  } norm_state_t;

  norm_state_t        state_r;
  logic signed [15:0] vx_r, vy_r;
  logic signed [31:0] vx32, vy32;
  logic [31:0]        sq;
  logic [63:0]        n_r;
  logic [33:0]        rem_r, rem_nxt;
  logic [31:0]        root_r, root_nxt;
  logic [35:0]        rem_sh, trial;
  logic [4:0]         it_r, dc_r;
  logic [15:0]        ax, ay;
  logic [31:0]        rx_r, ry_r, rx_nxt, ry_nxt;
  logic [32:0]        rx2, ry2, m33;
  logic               bx, by;
  logic [16:0]        qx_r, qy_r, qx_nxt, qy_nxt;
  logic signed [17:0] qxs, qys;
  logic               done_r;
  logic signed [17:0] ux_r, uy_r;

  assign rsp.done = done_r;
  assign rsp.ux   = ux_r;
  assign rsp.uy   = uy_r;

  always_comb begin
    vx32   = vx_r;
    vy32   = vy_r;
    sq     = 32'(vx32 * vx32) + 32'(vy32 * vy32);
    ax     = vx_r[15] ? 16'(~vx_r + 16'sd1) : 16'(vx_r);
    ay     = vy_r[15] ? 16'(~vy_r + 16'sd1) : 16'(vy_r);
    rem_sh = {rem_r, n_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = 34'(rem_sh - trial);
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      rem_nxt  = 34'(rem_sh);
      root_nxt = {root_r[30:0], 1'b0};
    end
    m33 = {1'b0, root_r};
    rx2 = {rx_r, 1'b0};
    ry2 = {ry_r, 1'b0};
    bx  = (rx2 >= m33);
    by  = (ry2 >= m33);
    rx_nxt = bx ? 32'(rx2 - m33) : rx2[31:0];
    ry_nxt = by ? 32'(ry2 - m33) : ry2[31:0];
    qx_nxt = {qx_r[15:0], bx};
    qy_nxt = {qy_r[15:0], by};
    qxs    = $signed({1'b0, qx_nxt});
    qys    = $signed({1'b0, qy_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        N_IDLE: begin
          if (req.start) begin
            vx_r    <= req.vx;
            vy_r    <= req.vy;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          if (sq == 32'd0) begin
            ux_r    <= '0;
            uy_r    <= '0;
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end else begin
            n_r     <= {sq, 32'd0};
            rem_r   <= '0;
            root_r  <= '0;
            it_r    <= 5'd31;
            state_r <= N_ROOT;
          end
        end
        N_ROOT: begin
          n_r    <= {n_r[61:0], 2'b00};
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          it_r   <= it_r - 5'd1;
          if (it_r == 5'd0) begin
            rx_r    <= {1'b0, ax, 15'd0};
            ry_r    <= {1'b0, ay, 15'd0};
            qx_r    <= '0;
            qy_r    <= '0;
            dc_r    <= 5'd16;
            state_r <= N_DIV;
          end
        end
        N_DIV: begin
          rx_r <= rx_nxt;
          ry_r <= ry_nxt;
          qx_r <= qx_nxt;
          qy_r <= qy_nxt;
          dc_r <= dc_r - 5'd1;
          if (dc_r == 5'd0) begin
            ux_r    <= vx_r[15] ? -qxs : qxs;
            uy_r    <= vy_r[15] ? -qys : qys;
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rk4st_back.sv =====
// Execution side: field store with clearing pass, RK4 sequencer, output register.
module rk4st_back #(
  parameter int GRID_W     = 256,
  parameter int GRID_H     = 256,
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(GRID_W+1)-1:0]      eff_w,
  input  logic [$clog2(GRID_H+1)-1:0]      eff_h,
  input  logic signed [15:0]               step,
  input  logic [$clog2(MAX_POINTS+1)-1:0]  n_pts,
  input  logic                             crop,
  output logic                             busy,
  input  logic                             empty,
  output logic                             pop,
  input  rk4st_pkg::cmd_t                  cmd,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rk4st_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tlast
);
  import rk4st_pkg::*;

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int IW    = $clog2(MAX_POINTS);
  localparam logic [25:0] DIV3_BIAS = 26'd25165824;
  localparam logic [25:0] RECIP3    = 26'd44739243;
  localparam logic signed [24:0] DIV3_OFS = 25'sd8388608;

  typedef enum logic [10:0] {
    B_CLEAR  = 11'b00000000001,
    B_IDLE   = 11'b00000000010,
    B_PROBE  = 11'b00000000100,
    B_READ   = 11'b00000001000,
    B_NSTART = 11'b00000010000,
    B_NWAIT  = 11'b00000100000,
    B_SCALE  = 11'b00001000000,
    B_ACCUM  = 11'b00010000000,
    B_DIV3   = 11'b00100000000,
    B_FINAL  = 11'b01000000000,
    B_EMIT   = 11'b10000000000
  } back_state_t;

  function automatic logic [12:0] cell_of(input logic signed [37:0] p, input logic [12:0] lim);
    logic [12:0] hi;
    hi = p[37:25];
    if (p[37]) begin
      cell_of = 13'd0;
    end else if (hi > lim - 13'd1) begin
      cell_of = lim - 13'd1;
    end else begin
      cell_of = hi;
    end
  endfunction

  function automatic logic signed [39:0] acc_init(input logic signed [19:0] p);
    logic signed [39:0] pe;
    pe = 40'(p);
    acc_init = (pe <<< 17) + (pe <<< 18) + 40'sd196608;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [24:0] v);
    if (v > 25'sd524287) begin
      sat20 = 20'sd524287;
    end else if (v < -25'sd524288) begin
      sat20 = -20'sd524288;
    end else begin
      sat20 = 20'(v);
    end
  endfunction

  back_state_t        state_r;
  logic [AW-1:0]      clr_addr_r, addr_r, addr_nxt, waddr;
  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data_r, wdata;
  logic               we;
  logic signed [19:0] pend_x_r, pend_y_r, nx_r, ny_r, sx, sy;
  logic [IW-1:0]      cnt_r;
  logic               emit_last_r;
  logic [1:0]         stage_r;
  logic signed [39:0] acc_x_r, acc_y_r;
  logic signed [33:0] kx_r, ky_r;
  logic signed [34:0] cxk, cyk;
  logic signed [37:0] probe_x, probe_y;
  logic [12:0]        cell_x, cell_y;
  logic signed [22:0] tx, ty;
  logic [25:0]        ubx, uby;
  logic [51:0]        prod_x_r, prod_y_r;
  logic signed [24:0] rxv, ryv;
  logic signed [20:0] wl, hl, sx21, sy21;
  logic               in_grid, load, last_step;
  norm_req_t          nreq;
  norm_rsp_t          nrsp;
  logic               out_valid_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  rk4st_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  assign busy       = (state_r == B_CLEAR);
  assign pop        = (state_r == B_IDLE) && !empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign load       = (state_r == B_EMIT) && (!out_valid_r || out_tready);
  assign last_step  = ((NW'(cnt_r) + NW'(1)) == (n_pts - NW'(1)));

  always_comb begin
    nreq.start = (state_r == B_NSTART);
    nreq.vx    = rd_data_r[15:0];
    nreq.vy    = rd_data_r[31:16];
    case (stage_r)
      2'd0:    begin cxk = '0;                 cyk = '0;                 end
      2'd3:    begin cxk = 35'(kx_r) <<< 1;    cyk = 35'(ky_r) <<< 1;    end
      default: begin cxk = 35'(kx_r);          cyk = 35'(ky_r);          end
    endcase
    probe_x  = (38'(pend_x_r) <<< 17) + 38'(cxk);
    probe_y  = (38'(pend_y_r) <<< 17) + 38'(cyk);
    cell_x   = cell_of(probe_x, 13'(eff_w));
    cell_y   = cell_of(probe_y, 13'(eff_h));
    addr_nxt = AW'(AW'(cell_y) * AW'(eff_w)) + AW'(cell_x);
    tx  = acc_x_r[39:17];
    ty  = acc_y_r[39:17];
    ubx = 26'(tx) + DIV3_BIAS;
    uby = 26'(ty) + DIV3_BIAS;
    rxv = $signed(prod_x_r[51:27]) - DIV3_OFS;
    ryv = $signed(prod_y_r[51:27]) - DIV3_OFS;
    sx  = sat20(rxv);
    sy  = sat20(ryv);
    sx21 = sx;
    sy21 = sy;
    wl  = $signed(21'({eff_w, 8'd0}));
    hl  = $signed(21'({eff_h, 8'd0}));
    in_grid = (sx > 20'sd0) && (sy > 20'sd0) && (sx21 < wl) && (sy21 < hl);
    we    = busy || (pop && !cmd.trace);
    waddr = busy ? clr_addr_r : AW'(cmd.addr);
    wdata = busy ? 32'd0 : {cmd.vec_y, cmd.vec_x};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {2'b00, IDX_W'(cnt_r), pend_y_r, pend_x_r};
        out_last_r  <= emit_last_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop && cmd.trace) begin
            pend_x_r <= cmd.pos_x;
            pend_y_r <= cmd.pos_y;
            cnt_r    <= '0;
            if (n_pts == NW'(1)) begin
              emit_last_r <= 1'b1;
              state_r     <= B_EMIT;
            end else begin
              acc_x_r <= acc_init(cmd.pos_x);
              acc_y_r <= acc_init(cmd.pos_y);
              stage_r <= 2'd0;
              state_r <= B_PROBE;
            end
          end
        end
        B_PROBE: begin
          addr_r  <= addr_nxt;
          state_r <= B_READ;
        end
        B_READ:   state_r <= B_NSTART;
        B_NSTART: state_r <= B_NWAIT;
        B_NWAIT: begin
          if (nrsp.done) begin
            state_r <= B_SCALE;
          end
        end
        B_SCALE: begin
          kx_r    <= 34'(34'(nrsp.ux) * 34'(step));
          ky_r    <= 34'(34'(nrsp.uy) * 34'(step));
          state_r <= B_ACCUM;
        end
        B_ACCUM: begin
          if (stage_r == 2'd1 || stage_r == 2'd2) begin
            acc_x_r <= acc_x_r + (40'(kx_r) <<< 1);
            acc_y_r <= acc_y_r + (40'(ky_r) <<< 1);
          end else begin
            acc_x_r <= acc_x_r + 40'(kx_r);
            acc_y_r <= acc_y_r + 40'(ky_r);
          end
          stage_r <= stage_r + 2'd1;
          state_r <= (stage_r == 2'd3) ? B_DIV3 : B_PROBE;
        end
        B_DIV3: begin
          prod_x_r <= 52'(ubx) * 52'(RECIP3);
          prod_y_r <= 52'(uby) * 52'(RECIP3);
          state_r  <= B_FINAL;
        end
        B_FINAL: begin
          nx_r        <= sx;
          ny_r        <= sy;
          emit_last_r <= crop && !in_grid;
          state_r     <= B_EMIT;
        end
        B_EMIT: begin
          if (load) begin
            if (emit_last_r) begin
              state_r <= B_IDLE;
            end else begin
              pend_x_r <= nx_r;
              pend_y_r <= ny_r;
              cnt_r    <= cnt_r + IW'(1);
              if (last_step) begin
                emit_last_r <= 1'b1;
              end else begin
                acc_x_r <= acc_init(nx_r);
                acc_y_r <= acc_init(ny_r);
                stage_r <= 2'd0;
                state_r <= B_PROBE;
              end
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rk4_streamline_tracer_core.sv =====
// Top level of the RK4 streamline tracer: config registers, front, queue, back.
// Write beat: stored in the field store when it is popped from the head of the queue.
// Trace beat: each RK4 step takes four field lookups, each bound by the
//   normalizer (bit-serial square root, then restoring divider); a point leaves
//   once the next one is known, so points follow one RK4 step apart.
// Reset: clearing pass over all GRID_W*GRID_H cells of the field store, in_tready low.
module rk4_streamline_tracer_core #(
  parameter int GRID_W     = 256,
  parameter int GRID_H     = 256,
  parameter int MAX_POINTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rk4st_pkg::IN_DATA_W-1:0]   in_tdata,   // pos_x, pos_y, vec_x, vec_y
  input  logic                              in_tuser,   // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rk4st_pkg::OUT_DATA_W-1:0]  out_tdata,  // point_x, point_y, point_index
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rk4st_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rk4st_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rk4st_pkg::*;

  localparam int WW  = $clog2(GRID_W + 1);
  localparam int HW  = $clog2(GRID_H + 1);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int EWW = (WW > 9) ? WW : 9;
  localparam int EHW = (HW > 9) ? HW : 9;

  logic [8:0]         gw_r, gh_r;
  logic signed [15:0] step_r;
  logic [6:0]         ppl_r;
  logic               crop_r;
  logic [EWW-1:0]     gw_ext;
  logic [EHW-1:0]     gh_ext;
  logic [WW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic [NW-1:0]      n_pts;
  logic               busy, full, push, pop, empty;
  cmd_t               cmd_in, cmd_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= 9'd256;
      gh_r   <= 9'd256;
      step_r <= 16'sd256;
      ppl_r  <= 7'd16;
      crop_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  gw_r   <= cfg_data[8:0];
        REG_GRID_HEIGHT: gh_r   <= cfg_data[8:0];
        REG_STEP_SIZE:   step_r <= cfg_data;
        REG_POINTS:      ppl_r  <= cfg_data[6:0];
        REG_CROP:        crop_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gw_ext = EWW'(gw_r);
    gh_ext = EHW'(gh_r);
    if (gw_r == 9'd0) begin
      eff_w = WW'(1);
    end else if (gw_ext > EWW'(GRID_W)) begin
      eff_w = WW'(GRID_W);
    end else begin
      eff_w = WW'(gw_ext);
    end
    if (gh_r == 9'd0) begin
      eff_h = HW'(1);
    end else if (gh_ext > EHW'(GRID_H)) begin
      eff_h = HW'(GRID_H);
    end else begin
      eff_h = HW'(gh_ext);
    end
    if (ppl_r == 7'd0) begin
      n_pts = NW'(1);
    end else if (ppl_r > 7'(MAX_POINTS)) begin
      n_pts = NW'(MAX_POINTS);
    end else begin
      n_pts = NW'(ppl_r);
    end
  end

  rk4st_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .busy      (busy),
    .full      (full),
    .push      (push),
    .cmd       (cmd_in)
  );

  rk4st_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (cmd_in),
    .full    (full),
    .pop     (pop),
    .cmd_out (cmd_out),
    .empty   (empty)
  );

  rk4st_back #(.GRID_W(GRID_W), .GRID_H(GRID_H), .MAX_POINTS(MAX_POINTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .step       (step_r),
    .n_pts      (n_pts),
    .crop       (crop_r),
    .busy       (busy),
    .empty      (empty),
    .pop        (pop),
    .cmd        (cmd_out),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/rk4st_checker.sv =====
// Port-level checks for the tracer core, bound to the top level.
module rk4st_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rk4st_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tlast
);
  import rk4st_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("beat offered or taken right after reset");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:46] == 2'b00)
    else $error("output padding not zero");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !(out_tvalid && out_tdata[45:40] == 6'd0))
    else $error("line restarted without a last beat");

endmodule

bind rk4_streamline_tracer_core rk4st_checker u_rk4st_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
